// ----- design/huffman_code_bit_packer_core_defines.svh -----
// assertion macros used by the checker file
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define HBP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define HBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define HBP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/hbp_pkg.sv -----
`default_nettype none

package hbp_pkg;

  // operation codes carried in tuser
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // input item field widths and positions in tdata
  localparam int OP_W      = 2;
  localparam int SYM_W     = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_IN_W  = 6;
  localparam int SYM_LO    = 0;
  localparam int CODE_LO   = SYM_LO + SYM_W;
  localparam int LEN_LO    = CODE_LO + CODE_W;
  localparam int S_TDATA_W = ((LEN_LO + LEN_IN_W + 7) / 8) * 8;

  // result item width
  localparam int OUT_W = 64;

  // default configuration
  localparam int DEF_MAX_CODE_BITS = 32;
  localparam int DEF_WORD_BITS     = 64;
  localparam int DEF_SYMBOL_COUNT  = 256;

  // output queue depth, power of two, at least two
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [OUT_W-1:0] word;
    logic             last;
  } out_item_t;

endpackage

`default_nettype wire

// ----- design/hbp_ram.sv -----
`default_nettype none

module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/huffman_code_bit_packer_core.sv -----
// Huffman code bit packer. A load item (tuser 0) writes one code table entry in the cycle it
// is accepted; the stored code is kept bit-reversed and aligned to bit 0 so that an encode needs
// only one shift. An encode item (tuser 1) or a finish item (tuser 2, which uses the code of
// symbol 0) reads the table in the cycle it is accepted; the registered table entry is appended to
// the bit buffer by the append stage, and words reach the output through the output queue. The
// block takes one item per cycle; the only limit is the four-entry output queue: the append
// stage waits until two entries are free, and the output drains one word per cycle while m_tready
// is high, and a finish may yield two words. Words carry the earliest coded bit in bit 0; the
// last word of a message is zero padded and marked by tlast. Table entries are undefined until
// loaded, and there is no clearing pass after reset.
`default_nettype none

module huffman_code_bit_packer_core #(
  parameter int MAX_CODE_BITS = hbp_pkg::DEF_MAX_CODE_BITS,
  parameter int WORD_BITS     = hbp_pkg::DEF_WORD_BITS,
  parameter int SYMBOL_COUNT  = hbp_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // symbol [7:0], code_value [39:8], code_length [45:40], zero [47:46]
  input  logic [hbp_pkg::S_TDATA_W-1:0] s_tdata,
  // operation [1:0]
  input  logic [hbp_pkg::OP_W-1:0]      s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // packed_word [63:0]
  output logic [hbp_pkg::OUT_W-1:0]     m_tdata,
  // last_word
  output logic                          m_tlast
);

  import hbp_pkg::*;

  localparam int ADDR_W   = $clog2(SYMBOL_COUNT);
  localparam int LEN_W    = $clog2(MAX_CODE_BITS + 1);
  localparam int ENTRY_W  = MAX_CODE_BITS + LEN_W;
  localparam int BUF_BITS = WORD_BITS + MAX_CODE_BITS;
  localparam int CNT_W    = $clog2(BUF_BITS + 1);
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam logic [SYM_W:0]    SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
  localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_CODE_BITS);
  localparam logic [CNT_W:0]    BUF_FULL  = (CNT_W + 1)'(BUF_BITS);
  localparam logic [CNT_W-1:0]  WORD_CNT  = CNT_W'(WORD_BITS);
  localparam logic [QCNT_W-1:0] Q_ROOM    = QCNT_W'(QDEPTH - 2);

  // input item fields
  logic [SYM_W-1:0]    in_sym;
  logic [CODE_W-1:0]   in_code;
  logic [LEN_IN_W-1:0] in_len;
  logic                in_accept;
  logic                sym_ok;
  logic                is_load;
  logic                is_encode;
  logic                is_finish;

  assign in_sym    = s_tdata[SYM_LO +: SYM_W];
  assign in_code   = s_tdata[CODE_LO +: CODE_W];
  assign in_len    = s_tdata[LEN_LO +: LEN_IN_W];
  assign in_accept = s_tvalid && s_tready;
  assign sym_ok    = {1'b0, in_sym} < SYM_LIMIT;
  assign is_load   = (s_tuser == OP_LOAD) && sym_ok;
  assign is_encode = (s_tuser == OP_ENCODE) && sym_ok;
  assign is_finish = (s_tuser == OP_FINISH);

  // load path: saturate length, reverse and align the code
  logic [LEN_W-1:0]         ld_len;
  logic [MAX_CODE_BITS-1:0] ld_rev;
  logic [MAX_CODE_BITS-1:0] ld_aligned;

  always_comb begin
    if (in_len > LEN_IN_W'(MAX_CODE_BITS)) begin
      ld_len = MAX_LEN;
    end else begin
      ld_len = LEN_W'(in_len);
    end
    for (int k = 0; k < MAX_CODE_BITS; k++) begin
      ld_rev[k] = in_code[MAX_CODE_BITS-1-k];
    end
    ld_aligned = ld_rev >> (MAX_LEN - ld_len);
  end

  // code table
  logic              tbl_we;
  logic              tbl_re;
  logic [ADDR_W-1:0] tbl_raddr;
  logic [ENTRY_W-1:0] tbl_rdata;

  assign tbl_we    = in_accept && is_load;
  assign tbl_re    = in_accept && (is_encode || is_finish);
  assign tbl_raddr = is_finish ? '0 : in_sym[ADDR_W-1:0];

  hbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_sym[ADDR_W-1:0]),
    .wdata ({ld_len, ld_aligned}),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // append stage control
  logic              st1_valid;
  logic              st1_finish;
  logic              fire;
  logic [QCNT_W-1:0] q_count;

  assign fire     = st1_valid && (q_count <= Q_ROOM);
  assign s_tready = !st1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid  <= 1'b0;
      st1_finish <= 1'b0;
    end else if (in_accept) begin
      st1_valid  <= is_encode || is_finish;
      st1_finish <= is_finish;
    end else if (fire) begin
      st1_valid  <= 1'b0;
    end
  end

  // append the looked-up code to the bit buffer
  logic [BUF_BITS-1:0]      bit_buffer;
  logic [CNT_W-1:0]         bit_count;
  logic [BUF_BITS-1:0]      bit_buffer_next;
  logic [CNT_W-1:0]         bit_count_next;
  logic [MAX_CODE_BITS-1:0] st1_code;
  logic [LEN_W-1:0]         st1_len;
  logic [BUF_BITS-1:0]      merged;
  logic [BUF_BITS-1:0]      rem_buf;
  logic [CNT_W:0]           total;
  logic [CNT_W-1:0]         new_cnt;
  logic                     emit_full;
  logic [WORD_BITS-1:0]     full_word;
  logic [WORD_BITS-1:0]     final_word;
  logic [1:0]               push_n;

  assign st1_code = tbl_rdata[MAX_CODE_BITS-1:0];
  assign st1_len  = tbl_rdata[ENTRY_W-1:MAX_CODE_BITS];

  always_comb begin
    merged = bit_buffer | (BUF_BITS'(st1_code) << bit_count);
    total  = (CNT_W + 1)'(bit_count) + (CNT_W + 1)'(st1_len);
    if (total > BUF_FULL) begin
      new_cnt = CNT_W'(BUF_BITS);
    end else begin
      new_cnt = total[CNT_W-1:0];
    end
    emit_full  = new_cnt >= WORD_CNT;
    rem_buf    = merged >> WORD_BITS;
    full_word  = merged[WORD_BITS-1:0];
    final_word = emit_full ? rem_buf[WORD_BITS-1:0] : merged[WORD_BITS-1:0];
    push_n     = {1'b0, emit_full} + {1'b0, st1_finish};
    if (st1_finish) begin
      bit_buffer_next = '0;
      bit_count_next  = '0;
    end else if (emit_full) begin
      bit_buffer_next = rem_buf;
      bit_count_next  = new_cnt - WORD_CNT;
    end else begin
      bit_buffer_next = merged;
      bit_count_next  = new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer <= '0;
      bit_count  <= '0;
    end else if (fire) begin
      bit_buffer <= bit_buffer_next;
      bit_count  <= bit_count_next;
    end
  end

  // output queue entries for this step
  out_item_t first_item;
  out_item_t second_item;

  always_comb begin
    if (emit_full) begin
      first_item.word = OUT_W'(full_word);
      first_item.last = 1'b0;
    end else begin
      first_item.word = OUT_W'(final_word);
      first_item.last = 1'b1;
    end
    second_item.word = OUT_W'(final_word);
    second_item.last = 1'b1;
  end

  // output queue
  out_item_t         q_mem [QDEPTH];
  logic [QPTR_W-1:0] q_head;
  logic [QPTR_W-1:0] q_tail;
  logic [QPTR_W-1:0] q_tail_p1;
  logic              pop;

  assign q_tail_p1 = q_tail + QPTR_W'(1);
  assign pop       = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (fire && (push_n != 2'd0)) begin
      q_mem[q_tail] <= first_item;
    end
    if (fire && (push_n == 2'd2)) begin
      q_mem[q_tail_p1] <= second_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      if (pop) begin
        q_head <= q_head + QPTR_W'(1);
      end
      if (fire) begin
        q_tail <= q_tail + QPTR_W'(push_n);
      end
      q_count <= q_count + (fire ? QCNT_W'(push_n) : '0) - QCNT_W'(pop);
    end
  end

  assign m_tvalid = q_count != '0;
  assign m_tdata  = q_mem[q_head].word;
  assign m_tlast  = q_mem[q_head].last;

endmodule

`default_nettype wire

// ----- design/hbp_checker.sv -----
`default_nettype none
`include "huffman_code_bit_packer_core_defines.svh"

module hbp_checker #(
  parameter int WORD_BITS = hbp_pkg::DEF_WORD_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [hbp_pkg::OUT_W-1:0] m_tdata,
  input  logic                      m_tlast
);

  import hbp_pkg::*;

  logic m_stall;

  assign m_stall = m_tvalid && !m_tready;

  // nothing is offered right after reset
  `HBP_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid, "output valid after reset")

  // a stalled word is still offered next cycle
  `HBP_ASSERT_NEXT(a_hold_valid, clk, rst, m_stall, m_tvalid, "output item dropped under stall")

  // a stalled word does not change
  `HBP_ASSERT_NEXT(a_hold_data, clk, rst, m_stall, $stable(m_tdata) && $stable(m_tlast), "output item changed under stall")

  // bits beyond the word size stay zero
  `HBP_ASSERT_IMPL(a_upper_zero, clk, rst, m_tvalid, (m_tdata >> WORD_BITS) == '0, "bits above word size set")

endmodule

bind huffman_code_bit_packer_core hbp_checker #(
  .WORD_BITS (WORD_BITS)
) u_hbp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
